/* rtl/snr_pkg.sv */
// Shared types and constants for the Snell refraction vector pipeline.
`timescale 1ns / 1ps
package snr_pkg;

    localparam int COMPONENT_BITS = 24;
    localparam int FRACTION_BITS  = 16;
    localparam int INDEX_BITS     = 16;
    localparam int ETA_BITS       = INDEX_BITS + FRACTION_BITS;
    localparam int PROD_BITS      = 48;

    localparam int DIV_PER_STAGE  = 4;
    localparam int DIV_STAGES     = ETA_BITS / DIV_PER_STAGE;

    localparam int SQRT_RAD_BITS  = 78;
    localparam int SQRT_ROOT_BITS = SQRT_RAD_BITS / 2;
    localparam int SQRT_REM_BITS  = SQRT_ROOT_BITS + 2;
    localparam int SQRT_PER_STAGE = 3;
    localparam int SQRT_STAGES    = SQRT_ROOT_BITS / SQRT_PER_STAGE;

    typedef logic signed [COMPONENT_BITS-1:0] t_comp;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TIR        = 2'd1,
        ST_ZERO_INDEX = 2'd2,
        ST_SAT        = 2'd3
    } t_status;

    typedef struct packed {
        t_comp                 incident_x;
        t_comp                 incident_y;
        t_comp                 incident_z;
        t_comp                 normal_x;
        t_comp                 normal_y;
        t_comp                 normal_z;
        logic [INDEX_BITS-1:0] index_from;
        logic [INDEX_BITS-1:0] index_to;
    } t_in;

    typedef struct packed {
        t_comp   refracted_x;
        t_comp   refracted_y;
        t_comp   refracted_z;
        t_status status;
    } t_out;

    // Per-item values carried alongside the arithmetic, in sign-magnitude form.
    typedef struct packed {
        logic [2:0][COMPONENT_BITS-1:0] nv_mag;
        logic [2:0]                     nv_neg;
        logic [2:0][COMPONENT_BITS-1:0] iv_mag;
        logic [2:0]                     iv_neg;
        logic [ETA_BITS-1:0]            eta;
        logic [PROD_BITS-1:0]           ec;
        logic                           zero_idx;
        logic                           tir;
        logic                           sat;
    } t_side;

endpackage

/* rtl/snr_div.sv */
// Pipelined restoring divider that forms eta = index_from * 2^F / index_to.
`timescale 1ns / 1ps
module snr_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [snr_pkg::INDEX_BITS-1:0] i_dividend,
    input  logic [snr_pkg::INDEX_BITS-1:0] i_divisor,
    input  snr_pkg::t_in                  i_side,
    output logic                          o_valid,
    output logic [snr_pkg::ETA_BITS-1:0]  o_quot,
    output snr_pkg::t_in                  o_side
);
    import snr_pkg::*;

    logic [DIV_STAGES-1:0] r_valid;
    logic [INDEX_BITS-1:0] r_rem  [DIV_STAGES];
    logic [ETA_BITS-1:0]   r_quot [DIV_STAGES];
    logic [ETA_BITS-1:0]   r_num  [DIV_STAGES];
    logic [INDEX_BITS-1:0] r_den  [DIV_STAGES];
    t_in                   r_side [DIV_STAGES];

    logic [INDEX_BITS-1:0] x_rem  [DIV_STAGES];
    logic [ETA_BITS-1:0]   x_quot [DIV_STAGES];
    logic [ETA_BITS-1:0]   x_num  [DIV_STAGES];
    logic [INDEX_BITS-1:0] x_den  [DIV_STAGES];
    logic [INDEX_BITS-1:0] n_rem  [DIV_STAGES];
    logic [ETA_BITS-1:0]   n_quot [DIV_STAGES];
    logic [ETA_BITS-1:0]   n_num  [DIV_STAGES];

    always_comb begin
        x_rem[0]  = '0;
        x_quot[0] = '0;
        x_num[0]  = {i_dividend, {FRACTION_BITS{1'b0}}};
        x_den[0]  = i_divisor;
        for (int s = 1; s < DIV_STAGES; s++) begin
            x_rem[s]  = r_rem[s-1];
            x_quot[s] = r_quot[s-1];
            x_num[s]  = r_num[s-1];
            x_den[s]  = r_den[s-1];
        end
    end

    always_comb begin
        logic [INDEX_BITS:0]   trial;
        logic [INDEX_BITS-1:0] rem;
        logic [ETA_BITS-1:0]   quot;
        logic [ETA_BITS-1:0]   num;
        for (int s = 0; s < DIV_STAGES; s++) begin
            rem  = x_rem[s];
            quot = x_quot[s];
            num  = x_num[s];
            for (int j = 0; j < DIV_PER_STAGE; j++) begin
                trial = {rem, num[ETA_BITS-1]};
                num   = num << 1;
                if (trial >= {1'b0, x_den[s]}) begin
                    trial = trial - {1'b0, x_den[s]};
                    quot  = {quot[ETA_BITS-2:0], 1'b1};
                end else begin
                    quot  = {quot[ETA_BITS-2:0], 1'b0};
                end
                rem = trial[INDEX_BITS-1:0];
            end
            n_rem[s]  = rem;
            n_quot[s] = quot;
            n_num[s]  = num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[DIV_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
        for (int s = 0; s < DIV_STAGES; s++) begin
            r_rem[s]  <= n_rem[s];
            r_quot[s] <= n_quot[s];
            r_num[s]  <= n_num[s];
            r_den[s]  <= x_den[s];
        end
        for (int s = 1; s < DIV_STAGES; s++) begin
            r_side[s] <= r_side[s-1];
        end
    end

    assign o_valid = r_valid[DIV_STAGES-1];
    assign o_quot  = r_quot[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];

endmodule

/* rtl/snr_sqrt.sv */
// Pipelined digit-by-digit integer square root, three root bits per stage.
`timescale 1ns / 1ps
module snr_sqrt (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [snr_pkg::SQRT_RAD_BITS-1:0]  i_radicand,
    input  snr_pkg::t_side                     i_side,
    output logic                               o_valid,
    output logic [snr_pkg::SQRT_ROOT_BITS-1:0] o_root,
    output snr_pkg::t_side                     o_side
);
    import snr_pkg::*;

    logic [SQRT_STAGES-1:0]    r_valid;
    logic [SQRT_REM_BITS-1:0]  r_rem  [SQRT_STAGES];
    logic [SQRT_ROOT_BITS-1:0] r_root [SQRT_STAGES];
    logic [SQRT_RAD_BITS-1:0]  r_rad  [SQRT_STAGES];
    t_side                     r_side [SQRT_STAGES];

    logic [SQRT_REM_BITS-1:0]  x_rem  [SQRT_STAGES];
    logic [SQRT_ROOT_BITS-1:0] x_root [SQRT_STAGES];
    logic [SQRT_RAD_BITS-1:0]  x_rad  [SQRT_STAGES];
    logic [SQRT_REM_BITS-1:0]  n_rem  [SQRT_STAGES];
    logic [SQRT_ROOT_BITS-1:0] n_root [SQRT_STAGES];
    logic [SQRT_RAD_BITS-1:0]  n_rad  [SQRT_STAGES];

    always_comb begin
        x_rem[0]  = '0;
        x_root[0] = '0;
        x_rad[0]  = i_radicand;
        for (int s = 1; s < SQRT_STAGES; s++) begin
            x_rem[s]  = r_rem[s-1];
            x_root[s] = r_root[s-1];
            x_rad[s]  = r_rad[s-1];
        end
    end

    // Each step brings down two radicand bits and tries root*4+1 against the remainder.
    always_comb begin
        logic [SQRT_REM_BITS+1:0]  t;
        logic [SQRT_REM_BITS+1:0]  trial;
        logic [SQRT_REM_BITS-1:0]  rem;
        logic [SQRT_ROOT_BITS-1:0] root;
        logic [SQRT_RAD_BITS-1:0]  rad;
        for (int s = 0; s < SQRT_STAGES; s++) begin
            rem  = x_rem[s];
            root = x_root[s];
            rad  = x_rad[s];
            for (int j = 0; j < SQRT_PER_STAGE; j++) begin
                t     = {rem, rad[SQRT_RAD_BITS-1 -: 2]};
                trial = {2'b00, root, 2'b01};
                rad   = rad << 2;
                if (t >= trial) begin
                    t    = t - trial;
                    root = {root[SQRT_ROOT_BITS-2:0], 1'b1};
                end else begin
                    root = {root[SQRT_ROOT_BITS-2:0], 1'b0};
                end
                rem = t[SQRT_REM_BITS-1:0];
            end
            n_rem[s]  = rem;
            n_root[s] = root;
            n_rad[s]  = rad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[SQRT_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
        for (int s = 0; s < SQRT_STAGES; s++) begin
            r_rem[s]  <= n_rem[s];
            r_root[s] <= n_root[s];
            r_rad[s]  <= n_rad[s];
        end
        for (int s = 1; s < SQRT_STAGES; s++) begin
            r_side[s] <= r_side[s-1];
        end
    end

    assign o_valid = r_valid[SQRT_STAGES-1];
    assign o_root  = r_root[SQRT_STAGES-1];
    assign o_side  = r_side[SQRT_STAGES-1];

endmodule

/* rtl/snell_refraction_vector.sv */
// Top level: fixed-point Snell refraction of a direction vector, fully pipelined.
//
//  Channel   Ports                      Transfer
//  --------  -------------------------  ------------------------------------
//  input     start, busy, i_data        edge with start high and busy low
//  result    o_strobe, o_result         every edge at which o_strobe is high
//
// One ray enters per clock; its result passes through 8 divider stages for eta,
// 13 square-root stages and 11 arithmetic stages before it appears.
// The latency is set by the eta divider, the square-root and the arithmetic stages.
// busy is always low; the receiver cannot stall, so nothing is ever held.
// Synchronous active-low reset clears all valid bits; payload is not reset.
`timescale 1ns / 1ps
module snell_refraction_vector (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  snr_pkg::t_in  i_data,
    output logic          o_strobe,
    output snr_pkg::t_out o_result
);
    import snr_pkg::*;

    localparam int LATENCY = DIV_STAGES + SQRT_STAGES + 11;
    localparam int CW      = COMPONENT_BITS;
    localparam logic [79:0] M_ONE = 80'd1 << FRACTION_BITS;
    localparam logic [79:0] M_LIM = 80'd1 << 60;
    localparam logic signed [58:0] V_MAX = (59'sd1 <<< (CW - 1)) - 59'sd1;
    localparam logic signed [58:0] V_MIN = -(59'sd1 <<< (CW - 1));

    logic                  div_valid;
    logic [ETA_BITS-1:0]   div_eta;
    t_in                   div_in;
    logic                  sq_valid;
    logic [SQRT_ROOT_BITS-1:0] sq_root;
    t_side                 sq_side;

    snr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start),
        .i_dividend (i_data.index_from),
        .i_divisor  (i_data.index_to),
        .i_side     (i_data),
        .o_valid    (div_valid),
        .o_quot     (div_eta),
        .o_side     (div_in)
    );

    // Stage registers.
    logic [10:1] r_valid;
    t_side r1_side, r2_side, r3_side, r4_side, r5_side, r6_side, r7_side;
    t_side r8_side, r9_side, r10_side;
    logic [PROD_BITS-1:0]     r1_prod [3];
    logic [2*ETA_BITS-1:0]    r1_ee;
    logic signed [33:0]       r2_dot;
    logic [PROD_BITS-1:0]     r2_e2, r3_e2, r4_e2;
    logic [2*ETA_BITS-1:0]    r3_cc, r3_ec;
    logic [PROD_BITS-1:0]     r4_tmag;
    logic                     r4_tneg, r5_tneg, r6_tneg;
    logic [PROD_BITS-1:0]     r5_pll, r5_plh, r5_phl, r5_phh;
    logic [79:0]              r6_m;
    logic [SQRT_RAD_BITS-1:0] r7_rad;
    logic [PROD_BITS-1:0]     r8_cmag;
    logic                     r8_cneg;
    logic [55:0]              r8_ei [3];
    logic [PROD_BITS-1:0]     r9_plo [3];
    logic [PROD_BITS-1:0]     r9_phi [3];
    logic [2:0]               r9_aneg;
    logic signed [58:0]       r9_b [3];
    logic signed [58:0]       r10_v [3];
    logic                     r_strobe;
    t_out                     r_result;

    // Next values.
    t_side n1_side, n3_side, n4_side, n7_side;
    logic [PROD_BITS-1:0]     n1_prod [3];
    logic [2*ETA_BITS-1:0]    n1_ee;
    logic signed [33:0]       n2_dot;
    logic [2*ETA_BITS-1:0]    n3_cc, n3_ec;
    logic [PROD_BITS-1:0]     n4_tmag;
    logic                     n4_tneg;
    logic [79:0]              n6_m;
    logic [SQRT_RAD_BITS-1:0] n7_rad;
    logic [PROD_BITS-1:0]     n8_cmag;
    logic                     n8_cneg;
    logic [55:0]              n8_ei [3];
    logic signed [58:0]       n9_b [3];
    logic signed [58:0]       n10_v [3];
    t_out                     n_result;

    always_comb begin
        t_comp                    iv [3];
        t_comp                    nv [3];
        logic signed [33:0]       term;
        logic signed [33:0]       cabs;
        logic [ETA_BITS-1:0]      c;
        logic [PROD_BITS-1:0]     ccs;
        logic [95:0]              full;
        logic [60:0]              k;
        logic signed [49:0]       coef;
        logic [72:0]              amag;
        logic signed [58:0]       a;
        logic                     clip;
        logic [2:0][CW-1:0]       comp;

        // Stage 1: sign-magnitude split, component products, eta squared.
        iv[0] = div_in.incident_x;
        iv[1] = div_in.incident_y;
        iv[2] = div_in.incident_z;
        nv[0] = div_in.normal_x;
        nv[1] = div_in.normal_y;
        nv[2] = div_in.normal_z;
        n1_side = '0;
        for (int i = 0; i < 3; i++) begin
            n1_side.iv_neg[i] = iv[i][CW-1];
            n1_side.nv_neg[i] = nv[i][CW-1];
            n1_side.iv_mag[i] = iv[i][CW-1] ? (~iv[i] + 1'b1) : iv[i];
            n1_side.nv_mag[i] = nv[i][CW-1] ? (~nv[i] + 1'b1) : nv[i];
            n1_prod[i] = n1_side.nv_mag[i] * n1_side.iv_mag[i];
        end
        n1_side.eta      = div_eta;
        n1_side.zero_idx = (div_in.index_to == '0);
        n1_ee = div_eta * div_eta;

        // Stage 2: dot product from truncated products.
        n2_dot = '0;
        for (int i = 0; i < 3; i++) begin
            term = $signed({2'b00, r1_prod[i][PROD_BITS-1:FRACTION_BITS]});
            if (r1_side.nv_neg[i] ^ r1_side.iv_neg[i]) begin
                term = -term;
            end
            n2_dot = n2_dot + term;
        end

        // Stage 3: flip the normal when it faces along the ray; c = |N.I|.
        n3_side = r2_side;
        if (!r2_dot[33]) begin
            n3_side.nv_neg = ~r2_side.nv_neg;
        end
        cabs  = r2_dot[33] ? -r2_dot : r2_dot;
        c     = cabs[ETA_BITS-1:0];
        n3_cc = c * c;
        n3_ec = r2_side.eta * c;

        // Stage 4: t = 1 - c^2 as sign and magnitude.
        n4_side    = r3_side;
        n4_side.ec = r3_ec[63:16];
        ccs        = r3_cc[63:16];
        n4_tneg    = ccs > PROD_BITS'(M_ONE);
        n4_tmag    = n4_tneg ? ccs - PROD_BITS'(M_ONE) : PROD_BITS'(M_ONE) - ccs;

        // Stage 6: assemble the 48x48 product of eta^2 and |t|.
        full = {r5_phh, 48'b0} + {24'b0, r5_plh, 24'b0} + {24'b0, r5_phl, 24'b0}
             + {48'b0, r5_pll};
        n6_m = full[95:16];

        // Stage 7: k = 1 - eta^2 t with the clamps, total internal reflection test.
        n7_side = r6_side;
        k       = '0;
        if (!r6_tneg) begin
            n7_side.tir = r6_m > M_ONE;
            k           = 61'(M_ONE - r6_m);
        end else if (r6_m > M_LIM - M_ONE) begin
            n7_side.sat = 1'b1;
            k           = 61'(M_LIM);
        end else begin
            k           = 61'(M_ONE + r6_m);
        end
        n7_rad = {1'b0, k, {FRACTION_BITS{1'b0}}};

        // Stage 8: coefficient eta c - sqrt(k), and eta times the incident vector.
        coef    = $signed({2'b00, sq_side.ec}) - $signed({11'b0, sq_root});
        n8_cneg = coef[49];
        n8_cmag = coef[49] ? PROD_BITS'(-coef) : coef[PROD_BITS-1:0];
        for (int i = 0; i < 3; i++) begin
            n8_ei[i] = sq_side.eta * sq_side.iv_mag[i];
        end

        // Stage 9: truncated eta*I terms.
        for (int i = 0; i < 3; i++) begin
            n9_b[i] = $signed({19'b0, r8_ei[i][55:16]});
            if (r8_side.iv_neg[i]) begin
                n9_b[i] = -n9_b[i];
            end
        end

        // Stage 10: N' * coef and the final sum.
        for (int i = 0; i < 3; i++) begin
            amag = {1'b0, r9_phi[i], 24'b0} + {25'b0, r9_plo[i]};
            a    = $signed({2'b00, amag[72:16]});
            if (r9_aneg[i]) begin
                a = -a;
            end
            n10_v[i] = a + r9_b[i];
        end

        // Stage 11: output clamp and status.
        clip = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (r10_v[i] > V_MAX) begin
                comp[i] = CW'(V_MAX);
                clip    = 1'b1;
            end else if (r10_v[i] < V_MIN) begin
                comp[i] = CW'(V_MIN);
                clip    = 1'b1;
            end else begin
                comp[i] = r10_v[i][CW-1:0];
            end
        end
        n_result.refracted_x = comp[0];
        n_result.refracted_y = comp[1];
        n_result.refracted_z = comp[2];
        if (r10_side.zero_idx) begin
            n_result = '0;
            n_result.status = ST_ZERO_INDEX;
        end else if (r10_side.tir) begin
            n_result = '0;
            n_result.status = ST_TIR;
        end else if (r10_side.sat || clip) begin
            n_result.status = ST_SAT;
        end else begin
            n_result.status = ST_OK;
        end
    end

    snr_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_valid[7]),
        .i_radicand (r7_rad),
        .i_side     (r7_side),
        .o_valid    (sq_valid),
        .o_root     (sq_root),
        .o_side     (sq_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_valid[7:1]  <= {r_valid[6:1], div_valid};
            r_valid[10:8] <= {r_valid[9:8], sq_valid};
            r_strobe      <= r_valid[10];
        end
    end

    always_ff @(posedge i_clk) begin
        r1_side <= n1_side;
        r1_prod <= n1_prod;
        r1_ee   <= n1_ee;

        r2_side <= r1_side;
        r2_dot  <= n2_dot;
        r2_e2   <= r1_ee[63:16];

        r3_side <= n3_side;
        r3_cc   <= n3_cc;
        r3_ec   <= n3_ec;
        r3_e2   <= r2_e2;

        r4_side <= n4_side;
        r4_tmag <= n4_tmag;
        r4_tneg <= n4_tneg;
        r4_e2   <= r3_e2;

        r5_side <= r4_side;
        r5_tneg <= r4_tneg;
        r5_pll  <= r4_e2[23:0]  * r4_tmag[23:0];
        r5_plh  <= r4_e2[23:0]  * r4_tmag[47:24];
        r5_phl  <= r4_e2[47:24] * r4_tmag[23:0];
        r5_phh  <= r4_e2[47:24] * r4_tmag[47:24];

        r6_side <= r5_side;
        r6_tneg <= r5_tneg;
        r6_m    <= n6_m;

        r7_side <= n7_side;
        r7_rad  <= n7_rad;

        r8_side <= sq_side;
        r8_cmag <= n8_cmag;
        r8_cneg <= n8_cneg;
        r8_ei   <= n8_ei;

        r9_side <= r8_side;
        r9_b    <= n9_b;
        for (int i = 0; i < 3; i++) begin
            r9_plo[i]  <= r8_side.nv_mag[i] * r8_cmag[23:0];
            r9_phi[i]  <= r8_side.nv_mag[i] * r8_cmag[47:24];
            r9_aneg[i] <= r8_side.nv_neg[i] ^ r8_cneg;
        end

        r10_side <= r9_side;
        r10_v    <= n10_v;

        r_result <= n_result;
    end

    assign busy     = 1'b0;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LATENCY o_strobe)
        else $error("accepted ray did not produce a result at the pipeline latency");

    a_no_orphan : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LATENCY))
        else $error("result strobe without a matching accepted ray");

    a_zero_vector : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.status == ST_TIR || o_result.status == ST_ZERO_INDEX)
        |-> o_result.refracted_x == '0 && o_result.refracted_y == '0
            && o_result.refracted_z == '0)
        else $error("reflection or zero-index result carries a nonzero vector");

endmodule
